// File: sv/gdcp_pkg.sv
// ----------------------------------------------------------------------------
// gdcp_pkg
// Shared types and constants of the display-control command port.
// ----------------------------------------------------------------------------
package gdcp_pkg;

    // Command codes in word bits 29:24.
    localparam logic [5:0] CMD_RESET      = 6'h00;
    localparam logic [5:0] CMD_FIFO_CLEAR = 6'h01;
    localparam logic [5:0] CMD_IRQ_ACK    = 6'h02;
    localparam logic [5:0] CMD_DISP_EN    = 6'h03;
    localparam logic [5:0] CMD_DMA_DIR    = 6'h04;
    localparam logic [5:0] CMD_DISP_START = 6'h05;
    localparam logic [5:0] CMD_HRANGE     = 6'h06;
    localparam logic [5:0] CMD_VRANGE     = 6'h07;
    localparam logic [5:0] CMD_DISP_MODE  = 6'h08;
    localparam logic [5:0] CMD_INFO_LO    = 6'h10;
    localparam logic [5:0] CMD_INFO_HI    = 6'h1F;

    // Info sub-codes in word bits 3:0.
    localparam logic [3:0] INFO_AREA_TL  = 4'd3;
    localparam logic [3:0] INFO_AREA_BR  = 4'd4;
    localparam logic [3:0] INFO_OFFSET   = 4'd5;
    localparam logic [3:0] INFO_VERSION  = 4'd7;

    // Configuration register indexes.
    localparam logic [2:0] CFG_DRAW_LEFT   = 3'd0;
    localparam logic [2:0] CFG_DRAW_TOP    = 3'd1;
    localparam logic [2:0] CFG_DRAW_RIGHT  = 3'd2;
    localparam logic [2:0] CFG_DRAW_BOTTOM = 3'd3;
    localparam logic [2:0] CFG_OFFSET_H    = 3'd4;
    localparam logic [2:0] CFG_OFFSET_V    = 3'd5;

    localparam logic [31:0] STATUS_RESET = 32'h1480_2000;
    localparam logic [21:0] GPU_VERSION  = 22'd2;

    // Display-side state, also the visible result fields.
    typedef struct packed {
        logic [31:0] status;
        logic [21:0] latch;
        logic [9:0]  disp_x;
        logic [8:0]  disp_y;
        logic [11:0] hstart;
        logic [11:0] hend;
        logic [9:0]  vstart;
        logic [9:0]  vend;
    } state_t;

    // Drawing area and offset values from the draw path.
    typedef struct packed {
        logic [9:0]  left;
        logic [9:0]  top;
        logic [9:0]  right;
        logic [9:0]  bottom;
        logic [10:0] off_h;
        logic [10:0] off_v;
    } draw_cfg_t;

    // One-transfer strobes of a command.
    typedef struct packed {
        logic fifo_clear;
        logic flip_clear;
        logic unknown;
    } flags_t;

endpackage

// File: sv/gdcp_exec.sv
// ----------------------------------------------------------------------------
// gdcp_exec
// Decodes one command word and computes the next display state and strobes.
// ----------------------------------------------------------------------------
module gdcp_exec (
    input  gdcp_pkg::state_t    state,
    input  gdcp_pkg::draw_cfg_t draw_cfg,
    input  logic [31:0]         word,
    output gdcp_pkg::state_t    state_next,
    output gdcp_pkg::flags_t    flags
);
    import gdcp_pkg::*;

    logic [5:0] cmd;
    logic [3:0] sub;

    assign cmd = word[29:24];
    assign sub = word[3:0];

    // Field updates for each command; unhandled codes leave the state alone.
    always_comb
    begin
        state_next = state;
        flags      = '0;
        case (cmd) inside
            CMD_RESET:
            begin
                state_next.status = STATUS_RESET;
                flags.flip_clear  = 1'b1;
            end
            CMD_FIFO_CLEAR:
            begin
                flags.fifo_clear = 1'b1;
            end
            CMD_IRQ_ACK:
            begin
                state_next.status[24] = 1'b0;
            end
            CMD_DISP_EN:
            begin
                state_next.status[23] = word[0];
            end
            CMD_DMA_DIR:
            begin
                state_next.status[30:29] = word[1:0];
            end
            CMD_DISP_START:
            begin
                state_next.disp_x = word[9:0];
                state_next.disp_y = word[18:10];
            end
            CMD_HRANGE:
            begin
                state_next.hstart = word[11:0];
                state_next.hend   = word[23:12];
            end
            CMD_VRANGE:
            begin
                state_next.vstart = word[9:0];
                state_next.vend   = word[19:10];
            end
            CMD_DISP_MODE:
            begin
                state_next.status[22:17] = word[5:0];
                state_next.status[16]    = word[6];
                state_next.status[15]    = state.status[15];
                state_next.status[14]    = word[7];
            end
            [CMD_INFO_LO:CMD_INFO_HI]:
            begin
                case (sub)
                    INFO_AREA_TL:
                        state_next.latch = {2'b00, draw_cfg.top, draw_cfg.left};
                    INFO_AREA_BR:
                        state_next.latch = {2'b00, draw_cfg.bottom, draw_cfg.right};
                    INFO_OFFSET:
                        state_next.latch = {draw_cfg.off_v, draw_cfg.off_h};
                    INFO_VERSION:
                        state_next.latch = GPU_VERSION;
                    default:
                        flags.unknown = 1'b1;
                endcase
            end
            default:
            begin
                flags.unknown = 1'b1;
            end
        endcase
    end

endmodule

// File: sv/gpu_display_control_port.sv
// ----------------------------------------------------------------------------
// gpu_display_control_port
// Display-control command port: status, display area and info latch updates.
// ----------------------------------------------------------------------------
// Usage:
// A command word is transferred on the cmd channel (cmd_valid, cmd_stall).
// It lands in an input register; when the result register is free the
// decode logic updates the display state and the result register, and the
// result is offered on the res channel (res_valid, res_stall). The state
// registers themselves serve as the result fields, so they only move when
// a result is loaded.
// Throughput is one command per clock while the receiver does not stall;
// the input register and the result register let a new command be taken
// while the previous result is still waiting.
// When the receiver stalls, the result holds, the input register fills and
// cmd_stall rises until the result is taken.
// The user must write drawing area and offset values on the cfg port only
// while idle; the block does not enforce this. Reset sets the status word to
// its power-on value, clears all other state and empties both registers.
// ----------------------------------------------------------------------------
module gpu_display_control_port (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port.
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [10:0] cfg_data,
    // Command channel.
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic [31:0] command_word,
    // Result channel.
    output logic        res_valid,
    input  logic        res_stall,
    output logic [31:0] status_word,
    output logic [21:0] info_latch,
    output logic [9:0]  start_x,
    output logic [8:0]  start_y,
    output logic [11:0] horiz_begin,
    output logic [11:0] horiz_finish,
    output logic [9:0]  vert_begin,
    output logic [9:0]  vert_finish,
    output logic        fifo_clear,
    output logic        flip_clear,
    output logic        unknown_command
);
    import gdcp_pkg::*;

    draw_cfg_t cfg_reg;
    logic      in_valid_reg;
    logic [31:0] in_word_reg;
    state_t    state_reg;
    state_t    state_next;
    flags_t    flags_reg;
    flags_t    flags_next;
    logic      res_valid_reg;
    logic      advance;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_DRAW_LEFT:   cfg_reg.left   <= cfg_data[9:0];
                CFG_DRAW_TOP:    cfg_reg.top    <= cfg_data[9:0];
                CFG_DRAW_RIGHT:  cfg_reg.right  <= cfg_data[9:0];
                CFG_DRAW_BOTTOM: cfg_reg.bottom <= cfg_data[9:0];
                CFG_OFFSET_H:    cfg_reg.off_h  <= cfg_data;
                CFG_OFFSET_V:    cfg_reg.off_v  <= cfg_data;
                default:         cfg_reg        <= cfg_reg;
            endcase
        end
    end

    // Handshake: a command moves on when the result register is free.
    assign advance   = in_valid_reg && (!res_valid_reg || !res_stall);
    assign cmd_stall = in_valid_reg && !advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!cmd_stall)
        begin
            in_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && !cmd_stall)
        begin
            in_word_reg <= command_word;
        end
    end

    // Command decode.
    gdcp_exec u_exec (
        .state      (state_reg),
        .draw_cfg   (cfg_reg),
        .word       (in_word_reg),
        .state_next (state_next),
        .flags      (flags_next)
    );

    // Display state and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= '{status: STATUS_RESET, default: '0};
            flags_reg        <= '0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
                flags_reg <= flags_next;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Result fields.
    assign res_valid       = res_valid_reg;
    assign status_word     = state_reg.status;
    assign info_latch      = state_reg.latch;
    assign start_x         = state_reg.disp_x;
    assign start_y         = state_reg.disp_y;
    assign horiz_begin     = state_reg.hstart;
    assign horiz_finish    = state_reg.hend;
    assign vert_begin      = state_reg.vstart;
    assign vert_finish     = state_reg.vend;
    assign fifo_clear      = flags_reg.fifo_clear;
    assign flip_clear      = flags_reg.flip_clear;
    assign unknown_command = flags_reg.unknown;

`ifndef SYNTHESIS
    // Only one strobe can come from a single command.
    a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(fifo_clear && flip_clear) && !(flip_clear && unknown_command))
        else $error("more than one command strobe in a result");

    // A texture-flip clear always comes with the power-on status word.
    a_flip_status: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && flip_clear) |-> (status_word == STATUS_RESET))
        else $error("status word not reset with flip clear");

    // The command side only stalls with a held command waiting.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> (in_valid_reg && res_valid && res_stall))
        else $error("command stall without a blocked result");

    // The display state does not move while a result waits on a stall.
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> $stable(state_reg))
        else $error("display state changed under a stalled result");
`endif

endmodule

// File: test/gpu_display_control_port_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gpu_display_control_port_tb
// Self-checking bench for the display-control command port. A shadow copy of
// the display state predicts every result from the accepted command words and
// the drawing-area registers. Results are checked in order, field by field,
// under several sender idle and receiver stall mixes.
// ----------------------------------------------------------------------------
module gpu_display_control_port_tb;

    import gdcp_pkg::*;

    // Codes that the port does not handle, used on purpose.
    localparam logic [5:0] CMD_UNUSED_FIRST = 6'h09;
    localparam logic [5:0] CMD_UNUSED_MID   = 6'h0F;
    localparam logic [5:0] CMD_UNUSED_HIGH  = 6'h20;
    localparam logic [5:0] CMD_UNUSED_LAST  = 6'h3F;
    localparam logic [3:0] INFO_SUB_NONE    = 4'h0;
    localparam logic [3:0] INFO_SUB_TOP     = 4'hF;
    // Register indexes past the last register; writes there are dropped.
    localparam logic [2:0] CFG_SPARE_LO     = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI     = 3'd7;

    localparam int RESULT_LATENCY   = 2;
    localparam int DRAIN_SETTLE     = 2 * RESULT_LATENCY + 2;
    localparam int PHASE_ITEMS      = 470;
    localparam int LONG_HOLD_CYCLES = 120;
    localparam int REPORT_LIMIT     = 10;
    localparam int CYCLE_LIMIT      = 200000;

    // One result transfer: all display registers plus the strobes.
    typedef struct packed {
        state_t regs;
        flags_t flags;
    } port_result_t;

    // Shadow of the display state and the queue of results still to arrive.
    class display_port_shadow;
        state_t       regs;
        draw_cfg_t    draw;
        port_result_t due_results[$];
        int           failures;

        function new();
            regs        = '0;
            regs.status = STATUS_RESET;
            draw        = '0;
            failures    = 0;
        endfunction

        function void load_draw_register(logic [2:0] index, logic [10:0] value);
            case (index)
                CFG_DRAW_LEFT:   draw.left   = value[9:0];
                CFG_DRAW_TOP:    draw.top    = value[9:0];
                CFG_DRAW_RIGHT:  draw.right  = value[9:0];
                CFG_DRAW_BOTTOM: draw.bottom = value[9:0];
                CFG_OFFSET_H:    draw.off_h  = value;
                CFG_OFFSET_V:    draw.off_v  = value;
                default:         ;
            endcase
        endfunction

        // Update the shadow state for one accepted command word.
        function void apply_command(logic [31:0] word);
            flags_t     strobes;
            logic [5:0] code;
            strobes = '0;
            code    = word[29:24];
            case (code)
                CMD_RESET:
                begin
                    regs.status        = STATUS_RESET;
                    strobes.flip_clear = 1'b1;
                end
                CMD_FIFO_CLEAR: strobes.fifo_clear = 1'b1;
                CMD_IRQ_ACK:    regs.status[24] = 1'b0;
                CMD_DISP_EN:    regs.status[23] = word[0];
                CMD_DMA_DIR:    regs.status[30:29] = word[1:0];
                CMD_DISP_START:
                begin
                    regs.disp_x = word[9:0];
                    regs.disp_y = word[18:10];
                end
                CMD_HRANGE:
                begin
                    regs.hstart = word[11:0];
                    regs.hend   = word[23:12];
                end
                CMD_VRANGE:
                begin
                    regs.vstart = word[9:0];
                    regs.vend   = word[19:10];
                end
                CMD_DISP_MODE:
                begin
                    regs.status[22:17] = word[5:0];
                    regs.status[16]    = word[6];
                    regs.status[14]    = word[7];
                end
                default:
                begin
                    if (code >= CMD_INFO_LO && code <= CMD_INFO_HI)
                    begin
                        // Unknown sub-codes leave the latch as it was.
                        case (word[3:0])
                            INFO_AREA_TL: regs.latch = {2'b00, draw.top, draw.left};
                            INFO_AREA_BR: regs.latch = {2'b00, draw.bottom, draw.right};
                            INFO_OFFSET:  regs.latch = {draw.off_v, draw.off_h};
                            INFO_VERSION: regs.latch = GPU_VERSION;
                            default:      strobes.unknown = 1'b1;
                        endcase
                    end
                    else
                    begin
                        strobes.unknown = 1'b1;
                    end
                end
            endcase
            due_results.push_back('{regs: regs, flags: strobes});
        endfunction

        function void report(string msg);
            failures++;
            if (failures <= REPORT_LIMIT)
            begin
                $display("[%0t] %s", $realtime, msg);
            end
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                report($sformatf("%s mismatch: expected 0x%0h, actual 0x%0h",
                                 field, want, got));
            end
        endfunction

        // Compare one result transfer with the oldest prediction.
        function void check_port_result(port_result_t got);
            port_result_t want;
            if (due_results.size() == 0)
            begin
                report($sformatf("result transfer with no command outstanding: %h", got));
                return;
            end
            want = due_results.pop_front();
            compare_field("status_word",     want.regs.status,      got.regs.status);
            compare_field("info_latch",      32'(want.regs.latch),  32'(got.regs.latch));
            compare_field("start_x",         32'(want.regs.disp_x), 32'(got.regs.disp_x));
            compare_field("start_y",         32'(want.regs.disp_y), 32'(got.regs.disp_y));
            compare_field("horiz_begin",     32'(want.regs.hstart), 32'(got.regs.hstart));
            compare_field("horiz_finish",    32'(want.regs.hend),   32'(got.regs.hend));
            compare_field("vert_begin",      32'(want.regs.vstart), 32'(got.regs.vstart));
            compare_field("vert_finish",     32'(want.regs.vend),   32'(got.regs.vend));
            compare_field("fifo_clear",      32'(want.flags.fifo_clear),
                          32'(got.flags.fifo_clear));
            compare_field("flip_clear",      32'(want.flags.flip_clear),
                          32'(got.flags.flip_clear));
            compare_field("unknown_command", 32'(want.flags.unknown),
                          32'(got.flags.unknown));
        endfunction

        function int due_count();
            return due_results.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [10:0] cfg_data;
    logic        cmd_valid;
    logic        cmd_stall;
    logic [31:0] command_word;
    logic        res_valid;
    logic        res_stall;
    logic [31:0] status_word;
    logic [21:0] info_latch;
    logic [9:0]  start_x;
    logic [8:0]  start_y;
    logic [11:0] horiz_begin;
    logic [11:0] horiz_finish;
    logic [9:0]  vert_begin;
    logic [9:0]  vert_finish;
    logic        fifo_clear;
    logic        flip_clear;
    logic        unknown_command;

    port_result_t       observed;
    display_port_shadow tracker;
    int                 send_idle_pct      = 0;
    int                 recv_stall_pct     = 0;
    bit                 receiver_hold_req  = 1'b0;
    bit                 receiver_hold_done = 1'b0;
    int                 cycle_count        = 0;

    gpu_display_control_port i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .cmd_valid       (cmd_valid),
        .cmd_stall       (cmd_stall),
        .command_word    (command_word),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .status_word     (status_word),
        .info_latch      (info_latch),
        .start_x         (start_x),
        .start_y         (start_y),
        .horiz_begin     (horiz_begin),
        .horiz_finish    (horiz_finish),
        .vert_begin      (vert_begin),
        .vert_finish     (vert_finish),
        .fifo_clear      (fifo_clear),
        .flip_clear      (flip_clear),
        .unknown_command (unknown_command)
    );

    assign observed = {status_word, info_latch, start_x, start_y, horiz_begin,
                       horiz_finish, vert_begin, vert_finish,
                       fifo_clear, flip_clear, unknown_command};

    // Clock generation.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watch both channels; a command is noted before a result is checked.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall)
            begin
                tracker.apply_command(command_word);
            end
            if (res_valid && !res_stall)
            begin
                tracker.check_port_result(observed);
            end
        end
    end

    // Abort a run that hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("gpu_display_control_port test failed");
            $finish;
        end
    end

    // Result receiver: random stalls, and one long hold-off when requested.
    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (receiver_hold_req && !receiver_hold_done)
            begin
                receiver_hold_done = 1'b1;
                for (int c = 0; c < LONG_HOLD_CYCLES; c++)
                begin
                    res_stall <= 1'b1;
                    @(negedge clk);
                end
            end
            res_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    function automatic logic [31:0] make_word(logic [1:0] top_bits, logic [5:0] code,
                                              logic [23:0] params);
        return {top_bits, code, params};
    endfunction

    // Random command: mostly handled commands, some info reads, some unknown codes.
    function automatic logic [31:0] random_command_word();
        logic [31:0] word;
        logic [5:0]  code;
        int          pick;
        word = $urandom;
        pick = $urandom_range(99);
        if (pick < 3)
        begin
            code = CMD_RESET;
        end
        else if (pick < 60)
        begin
            code = 6'($urandom_range(CMD_FIFO_CLEAR, CMD_DISP_MODE));
        end
        else if (pick < 92)
        begin
            code = 6'($urandom_range(CMD_INFO_LO, CMD_INFO_HI));
            if ($urandom_range(9) < 8)
            begin
                case ($urandom_range(3))
                    0:       word[3:0] = INFO_AREA_TL;
                    1:       word[3:0] = INFO_AREA_BR;
                    2:       word[3:0] = INFO_OFFSET;
                    default: word[3:0] = INFO_VERSION;
                endcase
            end
        end
        else
        begin
            do
                code = 6'($urandom_range(63));
            while (code <= CMD_DISP_MODE || (code >= CMD_INFO_LO && code <= CMD_INFO_HI));
        end
        word[29:24] = code;
        return word;
    endfunction

    // Offer one command word and wait for its transfer; returns at a falling edge.
    task automatic send_command(input logic [31:0] word);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid    <= 1'b0;
            command_word <= $urandom;
            @(negedge clk);
        end
        cmd_valid    <= 1'b1;
        command_word <= word;
        @(posedge clk);
        while (cmd_stall)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Stop offering and wait until every predicted result has arrived.
    task automatic wait_drained();
        cmd_valid <= 1'b0;
        while (tracker.due_count() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_SETTLE) @(negedge clk);
    endtask

    task automatic write_register(input logic [2:0] index, input logic [10:0] value);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        tracker.load_draw_register(index, value);
        @(negedge clk);
    endtask

    // Load all drawing registers, then poke the two unused indexes.
    task automatic program_draw_config(input logic [10:0] left, top, right, bottom,
                                       off_h, off_v);
        write_register(CFG_DRAW_LEFT, left);
        write_register(CFG_DRAW_TOP, top);
        write_register(CFG_DRAW_RIGHT, right);
        write_register(CFG_DRAW_BOTTOM, bottom);
        write_register(CFG_OFFSET_H, off_h);
        write_register(CFG_OFFSET_V, off_v);
        write_register(CFG_SPARE_LO, 11'($urandom_range(2047)));
        write_register(CFG_SPARE_HI, 11'($urandom_range(2047)));
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // One phase of random commands under a given idle and stall mix.
    task automatic run_phase(input int idle_pct, input int stall_pct, input bit long_hold);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            if (n == PHASE_ITEMS / 2)
            begin
                if (long_hold)
                begin
                    // Receiver holds off while commands keep coming.
                    receiver_hold_req = 1'b1;
                end
                else
                begin
                    wait_drained();
                end
            end
            send_command(random_command_word());
        end
        wait_drained();
    endtask

    // Main sequence.
    initial
    begin
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        cmd_valid    = 1'b0;
        command_word = '0;
        tracker      = new();
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed commands: every code, field extremes and the unhandled cases.
        program_draw_config(11'h3ff, 11'h000, 11'h000, 11'h3ff, 11'h400, 11'h3ff);
        send_command(make_word(2'b00, CMD_RESET,      24'h000000));
        send_command(make_word(2'b00, CMD_FIFO_CLEAR, 24'h000000));
        send_command(make_word(2'b00, CMD_IRQ_ACK,    24'hffffff));
        send_command(make_word(2'b00, CMD_DISP_EN,    24'h000001));
        send_command(make_word(2'b00, CMD_DISP_EN,    24'hfffffe));
        send_command(make_word(2'b00, CMD_DMA_DIR,    24'h000003));
        send_command(make_word(2'b00, CMD_DMA_DIR,    24'hfffffc));
        send_command(make_word(2'b00, CMD_DISP_START, 24'hffffff));
        send_command(make_word(2'b00, CMD_DISP_START, 24'h000000));
        send_command(make_word(2'b00, CMD_HRANGE,     24'hffffff));
        send_command(make_word(2'b00, CMD_VRANGE,     24'hffffff));
        send_command(make_word(2'b00, CMD_DISP_MODE,  24'h0000ff));
        send_command(make_word(2'b00, CMD_DISP_MODE,  24'hffff00));
        send_command(make_word(2'b00, CMD_INFO_LO,    {20'h00000, INFO_AREA_TL}));
        send_command(make_word(2'b00, CMD_INFO_HI,    {20'h00000, INFO_AREA_BR}));
        send_command(make_word(2'b11, CMD_INFO_LO + 6'd5, {20'hfffff, INFO_OFFSET}));
        send_command(make_word(2'b00, CMD_INFO_LO,    {20'h00000, INFO_VERSION}));
        send_command(make_word(2'b00, CMD_INFO_LO,    {20'h00000, INFO_SUB_NONE}));
        send_command(make_word(2'b11, CMD_INFO_HI,    {20'hfffff, INFO_SUB_TOP}));
        send_command(make_word(2'b00, CMD_UNUSED_FIRST, 24'h000000));
        send_command(make_word(2'b00, CMD_UNUSED_MID,   24'h123456));
        send_command(make_word(2'b00, CMD_UNUSED_HIGH,  24'h000000));
        send_command(make_word(2'b11, CMD_UNUSED_LAST,  24'hffffff));
        send_command(make_word(2'b11, CMD_DISP_EN,      24'h000001));
        send_command(make_word(2'b01, CMD_RESET,        24'h000000));
        wait_drained();

        // Random phases, each with its own drawing-area setting.
        program_draw_config(11'h7ff, 11'h7ff, 11'h7ff, 11'h7ff, 11'h7ff, 11'h7ff);
        run_phase(0, 0, 1'b1);
        program_draw_config(11'h000, 11'h000, 11'h000, 11'h000, 11'h000, 11'h000);
        run_phase(81, 0, 1'b0);
        program_draw_config(11'($urandom_range(2047)), 11'($urandom_range(2047)),
                            11'($urandom_range(2047)), 11'($urandom_range(2047)),
                            11'($urandom_range(2047)), 11'($urandom_range(2047)));
        run_phase(0, 81, 1'b0);
        program_draw_config(11'($urandom_range(2047)), 11'($urandom_range(2047)),
                            11'($urandom_range(2047)), 11'($urandom_range(2047)),
                            11'($urandom_range(2047)), 11'($urandom_range(2047)));
        run_phase(17, 17, 1'b0);

        if (tracker.failures == 0 && tracker.due_count() == 0)
        begin
            $display("gpu_display_control_port test passed");
        end
        else
        begin
            $display("gpu_display_control_port test failed");
        end
        $finish;
    end

endmodule
